// ===== design/mpl_pkg.sv =====
// Shared types, constants and helpers of the motor power limit scaler.
package mpl_pkg;

	localparam int MOTORS_DEF     = 4;
	localparam int SCALE_BITS_DEF = 10;
	localparam int SLOTS          = 4;

	localparam logic [63:0] TERM_CAP = 64'd1 << 58;
	localparam logic signed [63:0] POW_MAX = (64'sd1 <<< 47) - 64'sd1;
	localparam logic signed [63:0] POW_MIN = -(64'sd1 <<< 47);

	typedef enum logic [2:0] {
		REG_MOTOR_COUNT  = 3'd0,
		REG_POWER_BUDGET = 3'd1,
		REG_COPPER       = 3'd2,
		REG_IRON         = 3'd3,
		REG_STATIC       = 3'd4,
		REG_TORQUE_SCALE = 3'd5,
		REG_RATE_SCALE   = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		OUT_PASS   = 2'd0,
		OUT_SCALED = 2'd1,
		OUT_ZEROED = 2'd2
	} outcome_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRE,
		S_PRE_WAIT,
		S_EVAL,
		S_WAIT,
		S_SUM,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		EV_FULL,
		EV_ZERO,
		EV_MID
	} eval_kind_t;

	typedef enum logic [2:0] {
		OP_U  = 3'd0,
		OP_W  = 3'd1,
		OP_KW = 3'd2,
		OP_IW = 3'd3,
		OP_T  = 3'd4,
		OP_KT = 3'd5,
		OP_CT = 3'd6,
		OP_MT = 3'd7
	} op_t;

	typedef struct packed {
		logic [31:0] torque_scale;
		logic [31:0] rate_scale;
		logic [31:0] copper;
		logic [31:0] iron;
	} cell_cfg_t;

	typedef struct packed {
		logic start;
		logic eval;
	} cell_cmd_t;

	function automatic logic [47:0] sat48(input logic signed [63:0] v);
		logic signed [63:0] r;
		begin
			r = v;
			if (v > POW_MAX) begin
				r = POW_MAX;
			end else if (v < POW_MIN) begin
				r = POW_MIN;
			end
			sat48 = r[47:0];
		end
	endfunction

endpackage

// ===== design/mpl_if.sv =====
// Item channels of the motor power limit scaler.
interface mpl_cmd_if;
	logic valid;
	logic ready;
	logic signed [15:0] request_a;
	logic signed [15:0] request_b;
	logic signed [15:0] request_c;
	logic signed [15:0] request_d;
	logic signed [15:0] speed_a;
	logic signed [15:0] speed_b;
	logic signed [15:0] speed_c;
	logic signed [15:0] speed_d;
	modport source(output valid, request_a, request_b, request_c, request_d,
		speed_a, speed_b, speed_c, speed_d, input ready);
	modport sink(input valid, request_a, request_b, request_c, request_d,
		speed_a, speed_b, speed_c, speed_d, output ready);
endinterface

interface mpl_res_if;
	logic valid;
	logic ready;
	logic signed [15:0] drive_a;
	logic signed [15:0] drive_b;
	logic signed [15:0] drive_c;
	logic signed [15:0] drive_d;
	logic [10:0] scale_factor;
	logic signed [47:0] full_power;
	logic signed [47:0] capped_power;
	logic [1:0] outcome;
	modport source(output valid, drive_a, drive_b, drive_c, drive_d, scale_factor,
		full_power, capped_power, outcome, input ready);
	modport sink(input valid, drive_a, drive_b, drive_c, drive_d, scale_factor,
		full_power, capped_power, outcome, output ready);
endinterface

// ===== design/mpl_cell.sv =====
// One motor cell: multi-cycle loss terms and one link of the power sum chain.
module mpl_cell
	import mpl_pkg::*;
#(
	parameter int SCALE_BITS = SCALE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_cfg_t                cfg,
	input  logic                     load,
	input  logic signed [15:0]       req_in,
	input  logic signed [15:0]       spd_in,
	input  cell_cmd_t                cmd,
	input  logic [SCALE_BITS:0]      scale,
	input  logic                     active,
	input  logic [63:0]              sum_in,
	output logic [63:0]              sum_out,
	output logic                     done,
	output logic signed [15:0]       drive
);

	localparam int SW = SCALE_BITS + 1;

	op_t          op_q;
	logic [2:0]   phase_q;
	logic         busy_q;
	logic [63:0]  prod_q;
	logic [1:0]   pk_q;
	logic [127:0] acc_q;
	logic signed [15:0] req_q;
	logic signed [15:0] spd_q;
	logic [63:0]  u_q, w_q, kw_q, iw_q, t_q, kt_q, ct_q, mt_q;
	logic [63:0]  sum_q;

	logic [15:0]  req_mag, spd_mag;
	logic [63:0]  a_op, b_op;
	logic [6:0]   sh;
	logic         sat_en;
	logic [31:0]  a_h, b_h;
	logic [63:0]  part;
	logic [127:0] prod_ofs;
	logic [127:0] res_sh;
	logic [63:0]  res;
	logic         last_op;
	logic [63:0]  mt_s, term;
	logic [15+SW:0] drv_prod;
	logic [15:0]  drv_mag;

	assign req_mag = req_q[15] ? (~req_q + 16'd1) : req_q;
	assign spd_mag = spd_q[15] ? (~spd_q + 16'd1) : spd_q;

	always_comb begin
		a_op = 64'd0;
		b_op = 64'd0;
		sh = 7'd0;
		sat_en = 1'b0;
		case (op_q)
			OP_U: begin
				a_op = {48'd0, req_mag};
				b_op = {32'd0, cfg.torque_scale};
			end
			OP_W: begin
				a_op = {48'd0, spd_mag};
				b_op = {32'd0, cfg.rate_scale};
			end
			OP_KW: begin
				a_op = {32'd0, cfg.iron};
				b_op = w_q;
				sh = 7'd24;
				sat_en = 1'b1;
			end
			OP_IW: begin
				a_op = kw_q;
				b_op = w_q;
				sh = 7'd32;
				sat_en = 1'b1;
			end
			OP_T: begin
				a_op = u_q;
				b_op = 64'(scale);
				sh = 7'(SCALE_BITS);
			end
			OP_KT: begin
				a_op = {32'd0, cfg.copper};
				b_op = t_q;
				sh = 7'd24;
				sat_en = 1'b1;
			end
			OP_CT: begin
				a_op = kt_q;
				b_op = t_q;
				sh = 7'd32;
				sat_en = 1'b1;
			end
			OP_MT: begin
				a_op = w_q;
				b_op = t_q;
				sh = 7'd32;
				sat_en = 1'b1;
			end
			default: begin
				a_op = 64'd0;
			end
		endcase
	end

	assign a_h  = phase_q[1] ? a_op[63:32] : a_op[31:0];
	assign b_h  = phase_q[0] ? b_op[63:32] : b_op[31:0];
	assign part = {32'd0, a_h} * {32'd0, b_h};

	always_comb begin
		case (pk_q)
			2'd0: prod_ofs = {64'd0, prod_q};
			2'd3: prod_ofs = {prod_q, 64'd0};
			default: prod_ofs = {32'd0, prod_q, 32'd0};
		endcase
	end

	assign res_sh = acc_q >> sh;
	assign res = (sat_en && ((|res_sh[127:64]) || (res_sh[63:0] > TERM_CAP))) ?
		TERM_CAP : res_sh[63:0];
	assign last_op = (op_q == OP_IW) || (op_q == OP_MT);
	assign done = busy_q && (phase_q == 3'd5) && last_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			phase_q <= 3'd0;
			op_q <= OP_U;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			phase_q <= 3'd0;
			op_q <= cmd.eval ? OP_T : OP_U;
		end else if (busy_q) begin
			if (phase_q == 3'd5) begin
				phase_q <= 3'd0;
				if (last_op) begin
					busy_q <= 1'b0;
				end else begin
					op_q <= op_t'(op_q + 3'd1);
				end
			end else begin
				phase_q <= phase_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			req_q <= req_in;
			spd_q <= spd_in;
		end
		if (busy_q) begin
			if (phase_q < 3'd4) begin
				prod_q <= part;
				pk_q <= phase_q[1:0];
			end
			if (phase_q == 3'd0) begin
				acc_q <= 128'd0;
			end else if (phase_q < 3'd5) begin
				acc_q <= acc_q + prod_ofs;
			end else begin
				case (op_q)
					OP_U: u_q <= res;
					OP_W: w_q <= res;
					OP_KW: kw_q <= res;
					OP_IW: iw_q <= res;
					OP_T: t_q <= res;
					OP_KT: kt_q <= res;
					OP_CT: ct_q <= res;
					OP_MT: mt_q <= res;
					default: u_q <= u_q;
				endcase
			end
		end
	end

	assign mt_s = (req_q[15] ^ spd_q[15]) ? (64'd0 - mt_q) : mt_q;
	assign term = iw_q + ct_q + mt_s;

	always_ff @(posedge clk) begin
		sum_q <= sum_in + (active ? term : 64'd0);
	end

	assign sum_out = sum_q;

	assign drv_prod = {{SW{1'b0}}, req_mag} * {16'd0, scale};
	assign drv_mag = drv_prod[SCALE_BITS +: 16];
	assign drive = !active ? 16'sd0 :
		(req_q[15] ? $signed(~drv_mag + 16'd1) : $signed(drv_mag));

endmodule

// ===== design/motor_power_limit_scaler_unit.sv =====
// Top level of the motor power limit scaler: registers, sequencer and cell chain.
// Each item takes E power evaluations:
// one when the request fits, two when idle power is at or over budget, 2 + SCALE_BITS
// when bisecting; each evaluation is a start, four 64x64 products in every cell,
// then the ripple of the sum down the chain.
// One item at a time: the next item is accepted only after the result is loaded.
// Reset clears control state and loads the registers with their documented values.
module motor_power_limit_scaler_unit
	import mpl_pkg::*;
#(
	parameter int MOTORS     = MOTORS_DEF,
	parameter int SCALE_BITS = SCALE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	mpl_cmd_if.sink     cmd,
	mpl_res_if.source   result
);

	localparam int SW = SCALE_BITS + 1;
	localparam int IW = $clog2(SCALE_BITS);
	localparam int CW = $clog2(MOTORS + 1);
	localparam logic [SW-1:0] FULL = {1'b1, {SCALE_BITS{1'b0}}};

	logic [2:0]  motor_count_q;
	logic [31:0] budget_q, copper_q, iron_q, static_q, tscale_q, rscale_q;

	state_t      state_q, state_d;
	eval_kind_t  kind_q;
	logic [SW-1:0] s_q, lo_q, hi_q, lo_new, hi_new;
	logic [SW:0]   mid_sum;
	logic [IW-1:0] iter_q;
	logic [CW-1:0] cnt_q;
	logic [63:0]   req_pow_q, plo_q;
	outcome_t      outc_q;
	logic [63:0]   lim_q;

	logic        out_v_q;
	logic signed [15:0] drv_o_q [SLOTS];
	logic [10:0] scale_o_q;
	logic [47:0] reqp_o_q, limp_o_q;
	outcome_t    outc_o_q;

	cell_cfg_t   ccfg;
	cell_cmd_t   ccmd;
	logic [2:0]  n_use;
	logic        accept, sum_ready, fits, over_zero, done_all, go_out;
	logic [63:0] p;
	logic [63:0] budget64;
	logic [SW-1:0] scale_sat;

	logic signed [15:0] req_w [SLOTS];
	logic signed [15:0] spd_w [SLOTS];
	logic signed [15:0] drv_w [SLOTS];
	logic [63:0] chain [MOTORS+1];
	logic [MOTORS-1:0] done_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_count_q <= 3'd4;
			budget_q <= 32'd5242880;
			copper_q <= 32'd16777216;
			iron_q <= 32'd0;
			static_q <= 32'd0;
			tscale_q <= 32'd16777216;
			rscale_q <= 32'd16777216;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MOTOR_COUNT: motor_count_q <= cfg_data[2:0];
				REG_POWER_BUDGET: budget_q <= cfg_data;
				REG_COPPER: copper_q <= cfg_data;
				REG_IRON: iron_q <= cfg_data;
				REG_STATIC: static_q <= cfg_data;
				REG_TORQUE_SCALE: tscale_q <= cfg_data;
				REG_RATE_SCALE: rscale_q <= cfg_data;
				default: budget_q <= budget_q;
			endcase
		end
	end

	assign n_use = (motor_count_q > 3'(MOTORS)) ? 3'(MOTORS) : motor_count_q;
	assign ccfg = '{torque_scale: tscale_q, rate_scale: rscale_q,
		copper: copper_q, iron: iron_q};
	assign ccmd = '{start: (state_q == S_PRE) || (state_q == S_EVAL),
		eval: (state_q == S_EVAL)};

	assign req_w[0] = cmd.request_a;
	assign req_w[1] = cmd.request_b;
	assign req_w[2] = cmd.request_c;
	assign req_w[3] = cmd.request_d;
	assign spd_w[0] = cmd.speed_a;
	assign spd_w[1] = cmd.speed_b;
	assign spd_w[2] = cmd.speed_c;
	assign spd_w[3] = cmd.speed_d;

	assign chain[0] = {{32{static_q[31]}}, static_q};

	for (genvar i = 0; i < SLOTS; i++) begin : g_slot
		if (i < MOTORS) begin : g_cell
			mpl_cell #(.SCALE_BITS(SCALE_BITS)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.cfg     (ccfg),
				.load    (accept),
				.req_in  (req_w[i]),
				.spd_in  (spd_w[i]),
				.cmd     (ccmd),
				.scale   (s_q),
				.active  (3'(i) < n_use),
				.sum_in  (chain[i]),
				.sum_out (chain[i+1]),
				.done    (done_w[i]),
				.drive   (drv_w[i])
			);
		end else begin : g_none
			assign drv_w[i] = 16'sd0;
		end
	end

	assign done_all = &done_w;
	assign p = chain[MOTORS];
	assign budget64 = {32'd0, budget_q};
	assign fits = $signed(p) <= $signed(budget64);
	assign over_zero = $signed(p) >= $signed(budget64);
	assign sum_ready = (state_q == S_SUM) && (cnt_q == CW'(MOTORS));
	assign accept = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign go_out = !out_v_q || result.ready;

	assign lo_new = fits ? s_q : lo_q;
	assign hi_new = fits ? hi_q : s_q;
	assign mid_sum = {1'b0, lo_new} + {1'b0, hi_new};

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (cmd.valid) state_d = S_PRE;
			S_PRE: state_d = S_PRE_WAIT;
			S_PRE_WAIT: if (done_all) state_d = S_EVAL;
			S_EVAL: state_d = S_WAIT;
			S_WAIT: if (done_all) state_d = S_SUM;
			S_SUM: begin
				if (sum_ready) begin
					case (kind_q)
						EV_FULL: state_d = fits ? S_DONE : S_EVAL;
						EV_ZERO: state_d = over_zero ? S_DONE : S_EVAL;
						default: state_d = (iter_q == IW'(SCALE_BITS - 1)) ? S_DONE : S_EVAL;
					endcase
				end
			end
			S_DONE: if (go_out) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= EV_FULL;
			cnt_q <= '0;
			iter_q <= '0;
		end else begin
			if (accept) begin
				kind_q <= EV_FULL;
			end
			if (state_q == S_WAIT && done_all) begin
				cnt_q <= '0;
			end else if (state_q == S_SUM && !sum_ready) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (sum_ready) begin
				case (kind_q)
					EV_FULL: if (!fits) kind_q <= EV_ZERO;
					EV_ZERO: begin
						if (!over_zero) begin
							kind_q <= EV_MID;
							iter_q <= '0;
						end
					end
					default: iter_q <= iter_q + IW'(1);
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_q <= FULL;
		end
		if (sum_ready) begin
			case (kind_q)
				EV_FULL: begin
					req_pow_q <= p;
					if (fits) begin
						lim_q <= p;
						outc_q <= OUT_PASS;
					end else begin
						s_q <= '0;
					end
				end
				EV_ZERO: begin
					if (over_zero) begin
						lim_q <= p;
						outc_q <= OUT_ZEROED;
					end else begin
						lo_q <= '0;
						hi_q <= FULL;
						plo_q <= p;
						s_q <= FULL >> 1;
					end
				end
				default: begin
					lo_q <= lo_new;
					hi_q <= hi_new;
					if (fits) begin
						plo_q <= p;
					end
					if (iter_q == IW'(SCALE_BITS - 1)) begin
						s_q <= lo_new;
						lim_q <= fits ? p : plo_q;
						outc_q <= OUT_SCALED;
					end else begin
						s_q <= mid_sum[SW:1];
					end
				end
			endcase
		end
	end

	assign scale_sat = (s_q > SW'(2047)) ? SW'(2047) : s_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == S_DONE && go_out) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && go_out) begin
			for (int i = 0; i < SLOTS; i++) begin
				drv_o_q[i] <= drv_w[i];
			end
			scale_o_q <= 11'(scale_sat);
			reqp_o_q <= sat48(req_pow_q);
			limp_o_q <= sat48(lim_q);
			outc_o_q <= outc_q;
		end
	end

	assign result.valid = out_v_q;
	assign result.drive_a = drv_o_q[0];
	assign result.drive_b = drv_o_q[1];
	assign result.drive_c = drv_o_q[2];
	assign result.drive_d = drv_o_q[3];
	assign result.scale_factor = scale_o_q;
	assign result.full_power = reqp_o_q;
	assign result.capped_power = limp_o_q;
	assign result.outcome = outc_o_q;

endmodule
